// ===== rtl/core/plid_pkg.sv =====
`timescale 1ns / 1ps
// Package for the positional list insert/delete unit.
// Holds list sizing constants, operation and status codes, payload structs and the
// controller/datapath interface types. Depends on nothing.
package plid_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int POS_W    = 5;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_EMPTY = 2'd3;

    typedef struct packed {
        logic [1:0]        mode;
        logic [POS_W-1:0]  position;
        logic signed [31:0] value;
    } plid_req_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [4:0]         count;
        logic [1:0]         status;
    } plid_rsp_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } plid_state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } plid_cmd_t;

    typedef struct packed {
        logic rsp_blocked;
    } plid_sts_t;

endpackage

// ===== rtl/core/plid_ctrl.sv =====
`timescale 1ns / 1ps
// Controller for the positional list unit: takes a request, then fires the
// execute step once the response register is free. Depends on plid_pkg.
module plid_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  plid_pkg::plid_sts_t sts,
    output plid_pkg::plid_cmd_t cmd
);
    import plid_pkg::*;

    plid_state_t state_reg;
    plid_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        req_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // The result needs a free response register before the list is updated.
                if (!sts.rsp_blocked)
                begin
                    cmd.execute = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/plid_datapath.sv =====
`timescale 1ns / 1ps
// Datapath for the positional list unit: request register, row of list cells
// that shift in parallel, entry count and response register. Depends on plid_pkg.
module plid_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  plid_pkg::plid_req_t req,
    input  plid_pkg::plid_cmd_t cmd,
    output plid_pkg::plid_sts_t sts,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output plid_pkg::plid_rsp_t rsp
);
    import plid_pkg::*;

    plid_req_t          op_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic signed [31:0] entry_reg  [CAPACITY];
    logic signed [31:0] entry_next [CAPACITY];
    logic               rsp_valid_reg;
    plid_rsp_t          rsp_reg;
    plid_rsp_t          rsp_next;

    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   count_ext;
    logic               is_insert;
    logic               is_delete;
    logic               op_ok;
    logic               write_en;

    assign pos_ext   = CMP_W'(op_reg.position);
    assign count_ext = CMP_W'(count_reg);
    assign is_insert = (op_reg.mode == MODE_INSERT);
    assign is_delete = (op_reg.mode == MODE_DELETE);
    assign write_en  = cmd.execute && op_ok;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= req;
        end
    end

    // Status checks in the order the list defines: full or empty first, then position.
    always_comb
    begin
        op_ok               = 1'b0;
        count_next          = count_reg;
        rsp_next.read_value = '0;
        rsp_next.status     = STAT_OK;
        if (is_insert)
        begin
            priority if (count_ext == CMP_W'(CAPACITY))
            begin
                rsp_next.status = STAT_FULL;
            end
            else if (pos_ext > count_ext)
            begin
                rsp_next.status = STAT_RANGE;
            end
            else
            begin
                op_ok      = 1'b1;
                count_next = count_reg + CNT_W'(1);
            end
        end
        else
        begin
            priority if (count_reg == '0)
            begin
                rsp_next.status = STAT_EMPTY;
            end
            else if (pos_ext >= count_ext)
            begin
                rsp_next.status = STAT_RANGE;
            end
            else
            begin
                op_ok               = 1'b1;
                rsp_next.read_value = entry_reg[pos_ext[IDX_W-1:0]];
                if (is_delete)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
        end
        rsp_next.count = 5'(count_next);
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam logic [CMP_W-1:0] CELL = CMP_W'(i);

        always_comb
        begin
            entry_next[i] = entry_reg[i];
            if (is_insert)
            begin
                if (CELL == pos_ext)
                begin
                    entry_next[i] = op_reg.value;
                end
                else if (CELL > pos_ext)
                begin
                    if (i > 0)
                    begin
                        entry_next[i] = entry_reg[(i > 0) ? i - 1 : 0];
                    end
                end
            end
            else if (is_delete)
            begin
                if (CELL >= pos_ext)
                begin
                    if (i < CAPACITY - 1)
                    begin
                        entry_next[i] = entry_reg[(i < CAPACITY - 1) ? i + 1 : i];
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (write_en)
            begin
                entry_reg[i] <= entry_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (write_en)
            begin
                count_reg <= count_next;
            end
            if (cmd.execute)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign sts.rsp_blocked = rsp_valid_reg && rsp_stall;
    assign rsp_valid       = rsp_valid_reg;
    assign rsp             = rsp_reg;

endmodule

// ===== rtl/core/positional_list_insert_delete_unit.sv =====
`timescale 1ns / 1ps
// Top level of the positional list insert/delete unit: controller plus datapath.
// Depends on plid_pkg, plid_ctrl and plid_datapath.
//
// Usage: the list holds up to 16 signed 32-bit words in order. A request on the
// req channel (req_valid/req_stall, payload req) asks to insert a word at a
// position, delete the entry at a position, or read it. Each request gives one
// response on the rsp channel (rsp_valid/rsp_stall, payload rsp) carrying the
// read or removed word, the new entry count and a status code.
// An accepted request is registered; the execute step then updates the list and
// loads the response register once that is free. One request is handled at a
// time, by the controller's capture and execute steps; all list cells shift in the
// execute cycle. A new request is taken while the previous response still waits.
// When the receiver stalls, the response holds and a second request waits in the
// execute step, with req_stall high, until the response register is free.
// Reset empties the list (count zero) and drops any pending response; entry
// contents are not cleared, as only entries below the count are ever read.
module positional_list_insert_delete_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  plid_pkg::plid_req_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output plid_pkg::plid_rsp_t rsp
);
    import plid_pkg::*;

    plid_cmd_t cmd;
    plid_sts_t sts;

    plid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    plid_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// ===== rtl/core/plid_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the positional list unit and its bind to the top level.
// Depends on plid_pkg and positional_list_insert_delete_unit.
module plid_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input plid_pkg::plid_rsp_t rsp
);
    import plid_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed or dropped");

    // One request at a time: an accepted request blocks the next cycle.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted in two consecutive cycles");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.count <= 5'(CAPACITY))
        else $error("entry count above capacity");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != STAT_OK |-> rsp.read_value == 32'sd0)
        else $error("failed request returned a nonzero word");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == STAT_FULL |-> rsp.count == 5'(CAPACITY))
        else $error("full status without a full list");

endmodule

bind positional_list_insert_delete_unit plid_checker u_plid_checker (.*);
